// File: hdl/bnso_pkg.sv
// Shared types, constants and tables for the blue-noise swap optimiser.
// Used by bnso_term, blue_noise_swap_optimizer_top, bnso_checker and tb; depends on nothing else.
package bnso_pkg;

  localparam int SIDE_W   = 6;
  localparam int CELLS    = 1 << (2 * SIDE_W);
  localparam int ADDR_W   = 2 * SIDE_W;
  localparam int VAL_W    = 16;
  localparam int E_W      = 26;
  localparam int RADIUS   = 9;
  localparam int OFF_W    = 5;
  localparam int D2_W     = 8;
  localparam int TERM_W   = 17;
  localparam int EXP_STEPS = 12;

  localparam logic [E_W-1:0] E_MAX = {E_W{1'b1}};

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_EVAL  = 2'd1;
  localparam logic [1:0] CMD_SWAP  = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic CFG_SPATIAL = 1'b0;
  localparam logic CFG_VALUE   = 1'b1;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [SIDE_W-1:0] px;
    logic [SIDE_W-1:0] py;
    logic [SIDE_W-1:0] qx;
    logic [SIDE_W-1:0] qy;
    logic [VAL_W-1:0]  pixel_value;
  } in_t;

  typedef struct packed {
    logic             accepted;
    logic [E_W-1:0]   energy_first;
    logic [E_W-1:0]   energy_second;
    logic [VAL_W-1:0] read_value;
  } out_t;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] diff;
    logic [D2_W-1:0]  d2;
  } term_req_t;

  // round(exp(-2^(k-8)) * 2^30)
  function automatic logic [29:0] exp_coef(input logic [3:0] k);
    logic [29:0] c;
    case (k)
      4'd0:    c = 30'd1069555702;
      4'd1:    c = 30'd1065385899;
      4'd2:    c = 30'd1057095000;
      4'd3:    c = 30'd1040708260;
      4'd4:    c = 30'd1008687096;
      4'd5:    c = 30'd947573834;
      4'd6:    c = 30'd836230973;
      4'd7:    c = 30'd651257337;
      4'd8:    c = 30'd395007542;
      4'd9:    c = 30'd145315155;
      4'd10:   c = 30'd19666268;
      4'd11:   c = 30'd360200;
      default: c = 30'd0;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] sq(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'd0;
      4'd1:    s = 7'd1;
      4'd2:    s = 7'd4;
      4'd3:    s = 7'd9;
      4'd4:    s = 7'd16;
      4'd5:    s = 7'd25;
      4'd6:    s = 7'd36;
      4'd7:    s = 7'd49;
      4'd8:    s = 7'd64;
      4'd9:    s = 7'd81;
      default: s = 7'd0;
    endcase
    return s;
  endfunction

endpackage

// File: hdl/bnso_term.sv
// One window term: bit-serial square root, then a shared multiplier for the
// weights and the exponential steps. Depends on bnso_pkg.
module bnso_term import bnso_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  term_req_t         req,
  input  logic [15:0]       spatial_weight,
  input  logic [15:0]       value_weight,
  output logic              done,
  output logic [TERM_W-1:0] term
);

  typedef enum logic [5:0] {
    T_IDLE = 6'b000001,
    T_SQRT = 6'b000010,
    T_MULB = 6'b000100,
    T_MULA = 6'b001000,
    T_EXP  = 6'b010000,
    T_DONE = 6'b100000
  } tstate_t;

  tstate_t     state_r, state_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] res_r, res_nxt;
  logic [31:0] bit_r, bit_nxt;
  logic [D2_W-1:0] d2_r, d2_nxt;
  logic [24:0] t_r, t_nxt;
  logic [30:0] r_r, r_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [30:0] mul_a;
  logic [29:0] mul_b;
  logic [60:0] prod;
  logic [60:0] rnd;
  logic [32:0] trial;
  logic [16:0] u;

  assign prod  = 61'(mul_a) * 61'(mul_b);
  assign rnd   = prod + 61'(32'h2000_0000);
  assign trial = 33'(res_r) + 33'(bit_r);
  assign u     = t_r[24:8];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      T_MULB: begin
        mul_a = 31'(res_r[15:0]);
        mul_b = 30'(value_weight);
      end
      T_MULA: begin
        mul_a = 31'(d2_r);
        mul_b = 30'(spatial_weight);
      end
      T_EXP: begin
        mul_a = r_r;
        mul_b = exp_coef(k_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    res_nxt   = res_r;
    bit_nxt   = bit_r;
    d2_nxt    = d2_r;
    t_nxt     = t_r;
    r_nxt     = r_r;
    k_nxt     = k_r;
    case (state_r)
      T_IDLE: begin
        if (req.start) begin
          rem_nxt   = {req.diff, 16'd0};
          res_nxt   = '0;
          bit_nxt   = 32'h4000_0000;
          d2_nxt    = req.d2;
          state_nxt = T_SQRT;
        end
      end
      T_SQRT: begin
        if (33'(rem_r) >= trial) begin
          rem_nxt = rem_r - trial[31:0];
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          state_nxt = T_MULB;
        end
      end
      T_MULB: begin
        t_nxt     = 25'(prod[31:12]);
        state_nxt = T_MULA;
      end
      T_MULA: begin
        t_nxt     = t_r + 25'(prod[23:0]);
        state_nxt = T_EXP;
        k_nxt     = 4'(EXP_STEPS - 1);
        r_nxt     = 31'h4000_0000;
      end
      T_EXP: begin
        // Beyond twelve in Q.8 the term rounds to nothing.
        if (u >= 17'd3072) begin
          r_nxt     = '0;
          state_nxt = T_DONE;
        end else begin
          if (u[k_r]) begin
            r_nxt = 31'(rnd[60:30]);
          end
          k_nxt = k_r - 4'd1;
          if (k_r == 4'd0) begin
            state_nxt = T_DONE;
          end
        end
      end
      T_DONE: begin
        state_nxt = T_IDLE;
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    d2_r  <= d2_nxt;
    t_r   <= t_nxt;
    r_r   <= r_nxt;
    k_r   <= k_nxt;
  end

  logic [31:0] rterm;
  assign rterm = 32'(r_r) + 32'd8192;
  assign done  = (state_r == T_DONE);
  assign term  = rterm[30:14];

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> state_r == T_IDLE) else $error("term started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("term done held");
  a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> term <= 17'd65536) else $error("term above one");
`endif

endmodule

// File: hdl/blue_noise_swap_optimizer_top.sv
// Top level of the blue-noise swap optimiser: command sequencer, pixel and
// energy memories, window walk. Depends on bnso_pkg and bnso_term.
//
//   channel  direction  handshake             payload
//   in_      request in  in_valid / in_stall   in_data (in_t)
//   out_     result out  out_valid / out_stall out_data (out_t)
//   cfg_     write in    cfg_we                cfg_index, cfg_data
//
// An energy evaluation walks 361 window terms; each term takes a pixel read
// and the hand-over to the shared term unit, 16 square root steps, two weight
// products, up to 12 exponential steps and a finishing state.
// A trial swap runs two evaluations.
// Reset is synchronous and leaves the memories as they were; they are not
// cleared. A stalled result waits in the output register while the next
// request is taken.
module blue_noise_swap_optimizer_top import bnso_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_RD      = 18'h00002,
    S_SW_RQ   = 18'h00004,
    S_SW_WP   = 18'h00008,
    S_SW_WQ   = 18'h00010,
    S_EV_CEN  = 18'h00020,
    S_EV_CENW = 18'h00040,
    S_EV_RD   = 18'h00080,
    S_EV_ST   = 18'h00100,
    S_EV_WT   = 18'h00200,
    S_EV_END  = 18'h00400,
    S_SW_EP   = 18'h00800,
    S_SW_EQ   = 18'h01000,
    S_SW_CMP  = 18'h02000,
    S_SW_AWQ  = 18'h04000,
    S_SW_RWQ  = 18'h08000,
    S_FIN     = 18'h10000,
    S_SPARE   = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] spatial_r, value_r;
  logic [1:0]  cmd_r;
  logic [ADDR_W-1:0] p_r, q_r;
  logic [SIDE_W-1:0] cx_r, cy_r;
  logic        which_r;
  logic [VAL_W-1:0] vp_r, vq_r, cen_r, rv_r;
  logic [E_W-1:0]   e0_r, e1_r, ep_r, sum_r;
  logic        acc_r;
  logic signed [OFF_W-1:0] ox_r, oy_r;
  logic        out_valid_r;
  out_t        out_r;

  logic [VAL_W-1:0] pix_mem [CELLS];
  logic [E_W-1:0]   en_mem [CELLS];
  logic [VAL_W-1:0] prd_r;
  logic [E_W-1:0]   erd_r;
  logic [ADDR_W-1:0] pra, pwa, era, ewa;
  logic [VAL_W-1:0] pwd;
  logic [E_W-1:0]   ewd;
  logic             pwe, ewe;

  term_req_t        treq;
  logic             tdone;
  logic [TERM_W-1:0] tterm;

  logic accept;
  logic [ADDR_W-1:0] in_p, in_q;
  logic [SIDE_W-1:0] nx, ny;
  logic [3:0] adx, ady;
  logic [E_W:0] sum_add;
  logic [E_W:0] new_pair, old_pair;
  logic last;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_p     = {in_data.py, in_data.px};
  assign in_q     = {in_data.qy, in_data.qx};

  assign nx  = cx_r + SIDE_W'(ox_r);
  assign ny  = cy_r + SIDE_W'(oy_r);
  assign adx = ox_r[OFF_W-1] ? 4'(-ox_r) : 4'(ox_r);
  assign ady = oy_r[OFF_W-1] ? 4'(-oy_r) : 4'(oy_r);
  assign last = (ox_r == OFF_W'(RADIUS)) && (oy_r == OFF_W'(RADIUS));
  assign sum_add  = (E_W+1)'(sum_r) + (E_W+1)'(tterm);
  assign new_pair = (E_W+1)'(e0_r) + (E_W+1)'(e1_r);
  assign old_pair = (E_W+1)'(ep_r) + (E_W+1)'(erd_r);

  always_comb begin
    treq.start = (state_r == S_EV_ST);
    treq.diff  = (cen_r > prd_r) ? cen_r - prd_r : prd_r - cen_r;
    treq.d2    = D2_W'(sq(adx)) + D2_W'(sq(ady));
  end

  bnso_term u_term (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (treq),
    .spatial_weight (spatial_r),
    .value_weight   (value_r),
    .done           (tdone),
    .term           (tterm)
  );

  always_comb begin
    pra = {ny, nx};
    pwa = p_r;
    pwd = prd_r;
    pwe = 1'b0;
    era = p_r;
    ewa = p_r;
    ewd = sum_r;
    ewe = 1'b0;
    case (state_r)
      S_IDLE: begin
        pra = in_p;
        pwa = in_p;
        pwd = in_data.pixel_value;
        pwe = accept && (in_data.cmd == CMD_WRITE);
      end
      S_SW_RQ:  pra = q_r;
      S_SW_WP: begin
        pwa = p_r;
        pwd = prd_r;
        pwe = 1'b1;
      end
      S_SW_WQ: begin
        pwa = q_r;
        pwd = vp_r;
        pwe = 1'b1;
      end
      S_EV_CEN: pra = {cy_r, cx_r};
      S_EV_END: begin
        ewa = p_r;
        ewd = sum_r;
        ewe = (cmd_r == CMD_EVAL);
      end
      S_SW_EP:  era = p_r;
      S_SW_EQ:  era = q_r;
      S_SW_CMP: begin
        if (new_pair < old_pair) begin
          ewa = p_r;
          ewd = e0_r;
          ewe = 1'b1;
        end else begin
          pwa = p_r;
          pwd = vp_r;
          pwe = 1'b1;
        end
      end
      S_SW_AWQ: begin
        ewa = q_r;
        ewd = e1_r;
        ewe = 1'b1;
      end
      S_SW_RWQ: begin
        pwa = q_r;
        pwd = vq_r;
        pwe = 1'b1;
      end
      default: begin
        pra = {ny, nx};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pwe) begin
      pix_mem[pwa] <= pwd;
    end
    prd_r <= pix_mem[pra];
  end

  always_ff @(posedge clk) begin
    if (ewe) begin
      en_mem[ewa] <= ewd;
    end
    erd_r <= en_mem[era];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.cmd)
            CMD_WRITE: state_nxt = S_FIN;
            CMD_EVAL:  state_nxt = S_EV_CEN;
            CMD_SWAP:  state_nxt = S_SW_RQ;
            CMD_READ:  state_nxt = S_RD;
            default:   state_nxt = S_FIN;
          endcase
        end
      end
      S_RD:      state_nxt = S_FIN;
      S_SW_RQ:   state_nxt = S_SW_WP;
      S_SW_WP:   state_nxt = S_SW_WQ;
      S_SW_WQ:   state_nxt = S_EV_CEN;
      S_EV_CEN:  state_nxt = S_EV_CENW;
      S_EV_CENW: state_nxt = S_EV_RD;
      S_EV_RD:   state_nxt = S_EV_ST;
      S_EV_ST:   state_nxt = S_EV_WT;
      S_EV_WT: begin
        if (tdone) begin
          state_nxt = last ? S_EV_END : S_EV_RD;
        end
      end
      S_EV_END: begin
        if (cmd_r == CMD_EVAL) begin
          state_nxt = S_FIN;
        end else if (!which_r) begin
          state_nxt = S_EV_CEN;
        end else begin
          state_nxt = S_SW_EP;
        end
      end
      S_SW_EP:  state_nxt = S_SW_EQ;
      S_SW_EQ:  state_nxt = S_SW_CMP;
      S_SW_CMP: state_nxt = (new_pair < old_pair) ? S_SW_AWQ : S_SW_RWQ;
      S_SW_AWQ: state_nxt = S_FIN;
      S_SW_RWQ: state_nxt = S_FIN;
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      spatial_r   <= 16'd14861;
      value_r     <= 16'd4096;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_SPATIAL) begin
          spatial_r <= cfg_data;
        end else begin
          value_r <= cfg_data;
        end
      end
      if (state_r == S_FIN && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_r   <= in_data.cmd;
          p_r     <= in_p;
          q_r     <= in_q;
          cx_r    <= in_data.px;
          cy_r    <= in_data.py;
          which_r <= 1'b0;
          acc_r   <= 1'b0;
          e0_r    <= '0;
          e1_r    <= '0;
          rv_r    <= '0;
        end
      end
      S_RD:    rv_r <= prd_r;
      S_SW_RQ: vp_r <= prd_r;
      S_SW_WP: vq_r <= prd_r;
      S_EV_CENW: begin
        cen_r <= prd_r;
        sum_r <= '0;
        ox_r  <= -OFF_W'(RADIUS);
        oy_r  <= -OFF_W'(RADIUS);
      end
      S_EV_WT: begin
        if (tdone) begin
          sum_r <= sum_add[E_W] ? E_MAX : sum_add[E_W-1:0];
          if (ox_r == OFF_W'(RADIUS)) begin
            ox_r <= -OFF_W'(RADIUS);
            oy_r <= oy_r + OFF_W'(1);
          end else begin
            ox_r <= ox_r + OFF_W'(1);
          end
        end
      end
      S_EV_END: begin
        if (cmd_r == CMD_EVAL || !which_r) begin
          e0_r <= sum_r;
          which_r <= 1'b1;
          cx_r <= q_r[SIDE_W-1:0];
          cy_r <= q_r[ADDR_W-1:SIDE_W];
        end else begin
          e1_r <= sum_r;
        end
      end
      S_SW_EQ:  ep_r  <= erd_r;
      S_SW_CMP: acc_r <= (new_pair < old_pair);
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_r.accepted      <= acc_r;
          out_r.energy_first  <= e0_r;
          out_r.energy_second <= e1_r;
          out_r.read_value    <= rv_r;
        end
      end
      default: begin
        cmd_r <= cmd_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EV_WT |-> ox_r >= -OFF_W'(RADIUS) && ox_r <= OFF_W'(RADIUS)
      && oy_r >= -OFF_W'(RADIUS) && oy_r <= OFF_W'(RADIUS))
    else $error("window offset out of range");
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside finish");
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(pwe && ewe)) else $error("pixel and energy written together");
`endif

endmodule

// File: tb/bnso_checker.sv
// Checker for the blue-noise swap optimiser: watches the request, result and
// register ports, predicts every result and compares. Depends on bnso_pkg.
`timescale 1ns / 1ps
module bnso_checker import bnso_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_t        out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          fails,
  output int          pending
);

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  bit [VAL_W-1:0] pix_model [CELLS];
  bit [E_W-1:0]   energy_model [CELLS];
  bit [15:0]      spatial_w;
  bit [15:0]      value_w;
  out_t           expected_results [$];

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Decays by multiplying one table factor per set bit of the Q.8 exponent.
  function automatic longint unsigned decay_term(input longint unsigned t);
    longint unsigned u;
    longint unsigned r;
    u = t >> 8;
    r = ONE_Q30;
    if (u >= 12 * 256) return 0;
    for (int k = 11; k >= 0; k--) begin
      if (u[k]) r = (r * longint'(exp_coef(k[3:0])) + (ONE_Q30 >> 1)) >> 30;
    end
    return (r + 8192) >> 14;
  endfunction

  function automatic bit [E_W-1:0] window_energy(input bit [5:0] x, input bit [5:0] y);
    longint unsigned sum;
    longint unsigned ctr;
    longint unsigned oth;
    longint unsigned diff;
    longint unsigned a;
    longint unsigned b;
    bit [5:0] sx;
    bit [5:0] sy;
    int dx;
    int dy;
    sum = 0;
    ctr = pix_model[{y, x}];
    for (int oy = -RADIUS; oy <= RADIUS; oy++) begin
      for (int ox = -RADIUS; ox <= RADIUS; ox++) begin
        sx = 6'(int'(x) + ox);
        sy = 6'(int'(y) + oy);
        dx = ox < 0 ? -ox : ox;
        dy = oy < 0 ? -oy : oy;
        oth = pix_model[{sy, sx}];
        diff = ctr > oth ? ctr - oth : oth - ctr;
        a = longint'(dx * dx + dy * dy) * spatial_w;
        b = (int_sqrt(diff << 16) * value_w) >> 12;
        sum += decay_term(a + b);
        if (sum > E_MAX) sum = E_MAX;
      end
    end
    return sum[E_W-1:0];
  endfunction

  function automatic out_t predict_request(input in_t req);
    out_t r;
    bit [ADDR_W-1:0] p;
    bit [ADDR_W-1:0] q;
    bit [VAL_W-1:0] tmp;
    bit [E_W-1:0] e0;
    bit [E_W-1:0] e1;
    r = '0;
    p = {req.py, req.px};
    q = {req.qy, req.qx};
    case (req.cmd)
      CMD_WRITE: pix_model[p] = req.pixel_value;
      CMD_EVAL: begin
        e0 = window_energy(req.px, req.py);
        energy_model[p] = e0;
        r.energy_first = e0;
      end
      CMD_SWAP: begin
        tmp = pix_model[p];
        pix_model[p] = pix_model[q];
        pix_model[q] = tmp;
        e0 = window_energy(req.px, req.py);
        e1 = window_energy(req.qx, req.qy);
        if (27'(e0) + 27'(e1) < 27'(energy_model[p]) + 27'(energy_model[q])) begin
          energy_model[p] = e0;
          energy_model[q] = e1;
          r.accepted = 1'b1;
        end else begin
          tmp = pix_model[p];
          pix_model[p] = pix_model[q];
          pix_model[q] = tmp;
        end
        r.energy_first = e0;
        r.energy_second = e1;
      end
      default: r.read_value = pix_model[p];
    endcase
    return r;
  endfunction

  initial begin
    fails = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      spatial_w <= 16'd14861;
      value_w <= 16'd4096;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SPATIAL) spatial_w <= cfg_data;
        else value_w <= cfg_data;
      end
      if (in_valid && !in_stall) expected_results.push_back(predict_request(in_data));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: %p", out_data);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (want.accepted != out_data.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, out_data.accepted);
            fails++;
          end
          if (want.energy_first != out_data.energy_first) begin
            $error("energy_first: expected %0d, got %0d",
                   want.energy_first, out_data.energy_first);
            fails++;
          end
          if (want.energy_second != out_data.energy_second) begin
            $error("energy_second: expected %0d, got %0d",
                   want.energy_second, out_data.energy_second);
            fails++;
          end
          if (want.read_value != out_data.read_value) begin
            $error("read_value: expected %0d, got %0d",
                   want.read_value, out_data.read_value);
            fails++;
          end
        end
      end
      pending <= expected_results.size();
    end
  end

endmodule

// File: tb/tb.sv
// Top of the blue-noise swap optimiser testbench: clock, reset, requests,
// result back-pressure and verdict. Depends on bnso_pkg, bnso_checker and blue_noise_swap_optimizer_top.
`timescale 1ns / 1ps
module tb;
  import bnso_pkg::*;

  localparam longint CYCLE_LIMIT = 80_000_000;
  // Filled block of 22 by 22 pixels starting at 53 on both axes; centres at
  // 62, 63, 0 and 1 keep their whole window inside it.
  localparam int BLK_LO = 53;
  localparam int BLK_N  = 22;
  localparam int CTR_LO = 62;
  localparam int CTR_N  = 4;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  int          fails;
  int          pending;
  longint      cycles;
  bit          hold_req;
  bit          energy_known [CELLS];

  blue_noise_swap_optimizer_top uut (.*);

  bnso_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_SPATIAL;
    cfg_data = '0;
    rst_n = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request. The
  // request flag is cleared as the hold-off begins.
  initial begin
    int n;
    out_stall = 1'b0;
    hold_req = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      n = $urandom_range(0, 99);
      n = n < 55 ? 0 : n < 90 ? $urandom_range(1, 4) : $urandom_range(20, 120);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  task automatic send_request(input in_t req);
    logic stalled;
    int g;
    in_valid <= 1'b1;
    in_data <= req;
    if (req.cmd == CMD_EVAL) energy_known[{req.py, req.px}] = 1'b1;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    g = $urandom_range(0, 99);
    g = g < 60 ? 0 : g < 90 ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] v);
    drain();
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_t make_req(input logic [1:0] c, input int x0, input int y0,
                                   input int x1, input int y1, input int v);
    in_t r;
    r.cmd = c;
    r.px = x0[5:0];
    r.py = y0[5:0];
    r.qx = x1[5:0];
    r.qy = y1[5:0];
    r.pixel_value = v[15:0];
    return r;
  endfunction

  function automatic logic [5:0] block_coord();
    int c;
    c = (BLK_LO + int'($urandom_range(0, BLK_N - 1))) % 64;
    return c[5:0];
  endfunction

  function automatic logic [5:0] centre_coord();
    int c;
    c = (CTR_LO + int'($urandom_range(0, CTR_N - 1))) % 64;
    return c[5:0];
  endfunction

  // Reads stay in the filled block; evaluations and swaps use the centres,
  // and swaps only between pixels whose energies exist.
  function automatic in_t random_req();
    in_t r;
    int k;
    r = make_req(CMD_WRITE, int'(block_coord()), int'(block_coord()),
                 int'($urandom_range(0, 63)), int'($urandom_range(0, 63)),
                 int'($urandom_range(0, 65535)));
    k = $urandom_range(0, 99);
    if (k < 35) r.cmd = CMD_WRITE;
    else if (k < 60) r.cmd = CMD_READ;
    else begin
      r.px = centre_coord();
      r.py = centre_coord();
      r.cmd = CMD_EVAL;
      if (k >= 85) begin
        r.cmd = CMD_SWAP;
        r.qx = centre_coord();
        r.qy = centre_coord();
        if (!energy_known[{r.py, r.px}] || !energy_known[{r.qy, r.qx}])
          r.cmd = CMD_EVAL;
      end
    end
    return r;
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every pixel that is later read gets a value first.
    for (int row = 0; row < BLK_N; row++)
      for (int col = 0; col < BLK_N; col++)
        send_request(make_req(CMD_WRITE, (BLK_LO + col) % 64, (BLK_LO + row) % 64,
                              $urandom_range(0, 63), $urandom_range(0, 63),
                              $urandom_range(0, 65535)));

    send_request(make_req(CMD_WRITE, 0, 0, 63, 63, 0));
    send_request(make_req(CMD_WRITE, 63, 63, 0, 0, 65535));
    send_request(make_req(CMD_WRITE, 63, 0, 0, 63, 32768));
    send_request(make_req(CMD_READ, 0, 0, 63, 63, 65535));
    send_request(make_req(CMD_READ, 63, 63, 0, 0, 0));
    send_request(make_req(CMD_EVAL, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_EVAL, 63, 63, 0, 0, 0));
    send_request(make_req(CMD_EVAL, 63, 0, 0, 0, 0));
    send_request(make_req(CMD_EVAL, 1, 0, 0, 0, 0));
    send_request(make_req(CMD_SWAP, 0, 0, 63, 63, 0));
    send_request(make_req(CMD_SWAP, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_SWAP, 63, 63, 63, 63, 65535));
    send_request(make_req(CMD_SWAP, 1, 0, 0, 0, 0));
    send_request(make_req(CMD_SWAP, 63, 0, 0, 0, 0));
    send_request(make_req(CMD_READ, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_READ, 63, 63, 0, 0, 0));
    send_request(make_req(CMD_READ, 63, 0, 0, 0, 0));

    // Hold the results back while cheap requests keep coming.
    drain();
    hold_req = 1'b1;
    wait (!hold_req);
    for (int i = 0; i < 20; i++)
      send_request(make_req(CMD_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                            0, 0, $urandom_range(0, 65535)));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin
          write_reg(CFG_SPATIAL, 16'd0);
          write_reg(CFG_VALUE, 16'd0);
        end
        2: begin
          write_reg(CFG_SPATIAL, 16'hFFFF);
          write_reg(CFG_VALUE, 16'hFFFF);
        end
        3: begin
          write_reg(CFG_SPATIAL, 16'($urandom_range(0, 65535)));
          write_reg(CFG_VALUE, 16'($urandom_range(0, 65535)));
        end
        4: begin
          write_reg(CFG_SPATIAL, 16'd14861);
          write_reg(CFG_VALUE, 16'd4096);
        end
        default: ;
      endcase
      for (int i = 0; i < 46; i++) begin
        send_request(random_req());
        if (i == 23) drain();
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
